// File: rtl/xa_adpcm_pkg.sv
`default_nettype none

package xa_adpcm_pkg;

  // Block layout
  localparam int unsigned BLOCK_BYTES = 19;
  localparam int unsigned POS_W       = 5;

  localparam logic [POS_W-1:0] POS_FILTER     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_RAW_FIRST  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SHIFT      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_RAW_SECOND = POS_W'(3);
  localparam logic [POS_W-1:0] POS_FIRST_PAIR = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(BLOCK_BYTES - 1);

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned FILT_W   = 2;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned PCM_W    = 16;

  // Fixed-point history: signed, HIST_FRAC fraction bits
  localparam int unsigned HIST_W    = 32;
  localparam int unsigned HIST_FRAC = 8;

  // Filter coefficients, COEF_FRAC fraction bits
  localparam int unsigned COEF_W    = 10;
  localparam int unsigned COEF_FRAC = 8;
  localparam int unsigned FILT_NUM  = 4;
  localparam logic [SHIFT_W-1:0] FILT_MAX = SHIFT_W'(FILT_NUM - 1);

  localparam logic signed [COEF_W-1:0] COEF_A [FILT_NUM] = '{
    COEF_W'(0), COEF_W'(240), COEF_W'(460), COEF_W'(392)
  };
  localparam logic signed [COEF_W-1:0] COEF_B [FILT_NUM] = '{
    COEF_W'(0), COEF_W'(0), -COEF_W'(208), -COEF_W'(220)
  };

  // Nibble scale: 2^(SHIFT_LIMIT - shift) in sample units
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(12);
  localparam int unsigned        EXP_W       = 5;
  localparam logic [EXP_W-1:0]   BASE_EXP    = EXP_W'(12 + HIST_FRAC);

  // Controls for one prediction step
  typedef struct packed {
    logic [FILT_W-1:0]  filter;
    logic [SHIFT_W-1:0] shift;
    logic [NIB_W-1:0]   nibble;
  } pred_ctrl_t;

  // Result of one prediction step
  typedef struct packed {
    logic signed [HIST_W-1:0] hist;
    logic signed [PCM_W-1:0]  pcm;
  } pred_res_t;

endpackage

`default_nettype wire

// File: rtl/xa_adpcm_predict.sv
`default_nettype none

// One prediction step: scaled nibble plus two rounded taps, saturated to the
// history range, and the history value truncated toward zero to 16-bit PCM.
module xa_adpcm_predict (
  input  wire logic signed [xa_adpcm_pkg::HIST_W-1:0] hist_new_i,
  input  wire logic signed [xa_adpcm_pkg::HIST_W-1:0] hist_old_i,
  input  wire xa_adpcm_pkg::pred_ctrl_t               ctrl_i,
  output xa_adpcm_pkg::pred_res_t                     res_o
);
  import xa_adpcm_pkg::*;

  localparam int unsigned PROD_W = HIST_W + COEF_W;
  localparam int unsigned TAP_W  = PROD_W - COEF_FRAC;
  localparam int unsigned SUM_W  = TAP_W + 2;
  localparam int unsigned Q_W    = HIST_W + 1 - HIST_FRAC;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [HIST_W:0]   PCM_BIAS   = (HIST_W + 1)'((1 << HIST_FRAC) - 1);

  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [PROD_W-1:0] rnd_a;
  logic signed [PROD_W-1:0] rnd_b;
  logic signed [TAP_W-1:0]  tap_a;
  logic signed [TAP_W-1:0]  tap_b;
  logic signed [SUM_W-1:0]  nib_ext;
  logic signed [SUM_W-1:0]  base;
  logic [EXP_W-1:0]         exp_k;
  logic signed [SUM_W-1:0]  sum;
  logic signed [HIST_W-1:0] hist;
  logic signed [HIST_W:0]   hist_biased;
  logic signed [Q_W-1:0]    quot;
  logic signed [PCM_W-1:0]  pcm;

  // Taps: multiply, then round half up to the history format
  assign coef_a = COEF_A[ctrl_i.filter];
  assign coef_b = COEF_B[ctrl_i.filter];
  assign prod_a = PROD_W'(hist_new_i) * PROD_W'(coef_a);
  assign prod_b = PROD_W'(hist_old_i) * PROD_W'(coef_b);
  assign rnd_a  = prod_a + ROUND_HALF;
  assign rnd_b  = prod_b + ROUND_HALF;
  assign tap_a  = signed'(rnd_a[PROD_W-1:COEF_FRAC]);
  assign tap_b  = signed'(rnd_b[PROD_W-1:COEF_FRAC]);

  // Scaled nibble; large shifts leave only the taps
  assign nib_ext = SUM_W'(signed'(ctrl_i.nibble));
  assign exp_k   = BASE_EXP - EXP_W'(ctrl_i.shift);
  assign base    = (ctrl_i.shift <= SHIFT_LIMIT) ? (nib_ext <<< exp_k) : '0;

  assign sum = base + SUM_W'(tap_a) + SUM_W'(tap_b);

  // Saturate to the history range
  always_comb begin
    if (sum[SUM_W-1:HIST_W-1] == {(SUM_W - HIST_W + 1){sum[SUM_W-1]}}) begin
      hist = sum[HIST_W-1:0];
    end else if (sum[SUM_W-1]) begin
      hist = {1'b1, {(HIST_W - 1){1'b0}}};
    end else begin
      hist = {1'b0, {(HIST_W - 1){1'b1}}};
    end
  end

  // Truncate toward zero, then clamp to 16 bits
  assign hist_biased = (HIST_W + 1)'(hist) + (hist[HIST_W-1] ? PCM_BIAS : '0);
  assign quot        = signed'(hist_biased[HIST_W:HIST_FRAC]);

  always_comb begin
    if (quot[Q_W-1:PCM_W-1] == {(Q_W - PCM_W + 1){quot[Q_W-1]}}) begin
      pcm = quot[PCM_W-1:0];
    end else if (quot[Q_W-1]) begin
      pcm = {1'b1, {(PCM_W - 1){1'b0}}};
    end else begin
      pcm = {1'b0, {(PCM_W - 1){1'b1}}};
    end
  end

  assign res_o.hist = hist;
  assign res_o.pcm  = pcm;

endmodule

`default_nettype wire

// File: rtl/xa_adpcm_block_decoder_core.sv
`default_nettype none

// Channel   Dir  Beat                     tdata bits (low first)     tlast
// s_axis    in   one compressed byte      [7:0] data_byte            -
// m_axis    out  one decoded PCM sample   [15:0] sample              last_in_block
//
// Header bytes 0 and 2 give no beat; bytes 1 and 3 give one beat each; bytes
// 4..18 give two beats, one per nibble, taken in turn since each nibble's
// prediction feeds the next through the history registers.
// A block of 19 bytes gives 32 beats.
// Reset clears block position, filter, shift and history to zero.
// A one-byte input register and the output register let a new byte enter
// while a sample waits; a stalled output holds each decode step that gives a beat.
module xa_adpcm_block_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [15:0]     m_axis_tdata_o,   // [15:0] sample
  output logic            m_axis_tlast_o    // last_in_block
);
  import xa_adpcm_pkg::*;

  logic                     in_vld_q, in_vld_d;
  logic [BYTE_W-1:0]        in_byte_q, in_byte_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic                     phase_q, phase_d;
  logic [FILT_W-1:0]        filter_q, filter_d;
  logic [SHIFT_W-1:0]       shift_q, shift_d;
  logic [NIB_W-1:0]         pend_q, pend_d;
  logic signed [HIST_W-1:0] hist_new_q, hist_new_d;
  logic signed [HIST_W-1:0] hist_old_q, hist_old_d;
  logic                     out_vld_q, out_vld_d;
  logic signed [PCM_W-1:0]  out_sample_q, out_sample_d;
  logic                     out_last_q, out_last_d;

  logic [POS_W-1:0]         pos_eff;
  logic                     is_hdr;
  logic                     is_raw;
  logic                     out_free;
  logic                     step;
  logic                     emit;
  logic                     byte_done;
  logic signed [PCM_W-1:0]  raw_pcm;
  logic signed [HIST_W-1:0] raw_hist;
  pred_ctrl_t               pred_ctrl;
  pred_res_t                pred_res;

  // Decode the position of the buffered byte
  assign pos_eff  = (pos_q > POS_LAST) ? POS_FILTER : pos_q;
  assign is_hdr   = (pos_eff == POS_FILTER) || (pos_eff == POS_SHIFT);
  assign is_raw   = (pos_eff == POS_RAW_FIRST) || (pos_eff == POS_RAW_SECOND);
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Advance one step when the byte is ready and its beat has room
  assign step      = in_vld_q && (is_hdr || out_free);
  assign emit      = step && !is_hdr;
  assign byte_done = step && (is_hdr || is_raw || phase_q);

  assign s_axis_tready_o = !in_vld_q || byte_done;

  // Raw starting sample: signed byte * 256 + held nibble * 16
  assign raw_pcm  = {in_byte_q, pend_q, {(PCM_W - BYTE_W - NIB_W){1'b0}}};
  assign raw_hist = HIST_W'(raw_pcm) <<< HIST_FRAC;

  assign pred_ctrl.filter = filter_q;
  assign pred_ctrl.shift  = shift_q;
  assign pred_ctrl.nibble = phase_q ? in_byte_q[NIB_W-1:0] : in_byte_q[BYTE_W-1:NIB_W];

  xa_adpcm_predict u_predict (
    .hist_new_i (hist_new_q),
    .hist_old_i (hist_old_q),
    .ctrl_i     (pred_ctrl),
    .res_o      (pred_res)
  );

  // Input buffer
  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (s_axis_tready_o) begin
      in_vld_d = s_axis_tvalid_i;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_d = s_axis_tdata_i;
    end
  end

  // Block position, nibble phase and header fields
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    filter_d = filter_q;
    shift_d  = shift_q;
    pend_d   = pend_q;
    if (step && !is_hdr && !is_raw) begin
      phase_d = !phase_q;
    end
    if (byte_done) begin
      pos_d = (pos_eff == POS_LAST) ? POS_FILTER : pos_eff + POS_W'(1);
    end
    if (step && is_hdr) begin
      pend_d = in_byte_q[BYTE_W-1:NIB_W];
      if (pos_eff == POS_FILTER) begin
        filter_d = (in_byte_q[NIB_W-1:0] <= FILT_MAX) ? in_byte_q[FILT_W-1:0] : '0;
      end else begin
        shift_d = in_byte_q[NIB_W-1:0];
      end
    end
  end

  // History and output register
  always_comb begin
    hist_new_d   = hist_new_q;
    hist_old_d   = hist_old_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    if (emit) begin
      hist_old_d   = hist_new_q;
      hist_new_d   = is_raw ? raw_hist : pred_res.hist;
      out_sample_d = is_raw ? raw_pcm : pred_res.pcm;
      out_last_d   = !is_raw && phase_q && (pos_eff == POS_LAST);
      out_vld_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      pos_q      <= POS_FILTER;
      phase_q    <= 1'b0;
      filter_q   <= '0;
      shift_q    <= '0;
      pend_q     <= '0;
      hist_new_q <= '0;
      hist_old_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      pos_q      <= pos_d;
      phase_q    <= phase_d;
      filter_q   <= filter_d;
      shift_q    <= shift_d;
      pend_q     <= pend_d;
      hist_new_q <= hist_new_d;
      hist_old_q <= hist_old_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_byte_q    <= in_byte_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_sample_q;
  assign m_axis_tlast_o  = out_last_q;

  // The block position stays inside the block
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LAST)
    else $error("block position out of range");

  // The second nibble is only pending on a buffered data byte
  a_phase_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (in_vld_q && (pos_q >= POS_FIRST_PAIR)))
    else $error("nibble phase set without a data byte");

  // The last sample of a block wraps the position to the block start
  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last_d) |=> (pos_q == POS_FILTER) && !phase_q)
    else $error("block end did not wrap the position");

  // A beat is emitted only when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !emit)
    else $error("pending sample overwritten");

endmodule

`default_nettype wire
